[hdl/arp_cache_table_macros.svh]
// Assertion macros shared by the ARP cache table RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ARP_CACHE_TABLE_MACROS_SVH
`define ARP_CACHE_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARPCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/arpct_pkg.sv]
package arpct_pkg;

  // Field widths of the request and response channels.
  localparam int OP_W    = 1;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_OUT_W = 5;

  // Default table depth.
  localparam int DEF_TABLE_ENTRIES = 16;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 1'b0;
  localparam logic [OP_W-1:0] OP_ADD    = 1'b1;

endpackage

[hdl/arpct_if.sv]
// Request channel: operation, IPv4 address and MAC address.
interface arpct_req_if;
  logic                         valid;
  logic                         ready;
  logic [arpct_pkg::OP_W-1:0]   operation;
  logic [arpct_pkg::IP_W-1:0]   ip_addr;
  logic [arpct_pkg::MAC_W-1:0]  mac_addr;

  modport source (output valid, output operation, output ip_addr, output mac_addr,
                  input ready);
  modport sink   (input valid, input operation, input ip_addr, input mac_addr,
                  output ready);
endinterface

// Response channel: one result per request.
interface arpct_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [arpct_pkg::IDX_OUT_W-1:0]  entry_index;
  logic [arpct_pkg::MAC_W-1:0]      mac_found;
  logic                             table_flushed;
  logic [arpct_pkg::CNT_OUT_W-1:0]  entry_count;

  modport source (output valid, output hit, output entry_index, output mac_found,
                  output table_flushed, output entry_count, input ready);
  modport sink   (input valid, input hit, input entry_index, input mac_found,
                  input table_flushed, input entry_count, output ready);
endinterface

[hdl/arp_cache_table.sv]
// ARP cache table: TABLE_ENTRIES IPv4-to-MAC pairs, of which entries 0 to count-1
// are valid. A lookup request scans the valid entries in order and reports the
// first exact IPv4 match with its index and MAC; a miss reports zeros. An add
// request first empties the table if it is full, then scans for the address:
// a hit overwrites that entry's MAC, a miss appends the pair and bumps the count.
// One request is handled at a time. A single registered-read port on the table
// memory feeds one 32-bit comparator, one entry per cycle; the scan reads the
// valid entries in order, and a hit on entry j ends the scan early. The next
// request can be accepted in the cycle after the result is loaded. The result
// sits in an output register, so a new request may be accepted while the
// previous result is still waiting; the request after that stalls until the
// waiting result is taken.
// Table contents are not cleared at reset; the fill count is.
`include "arp_cache_table_macros.svh"

module arp_cache_table #(
  parameter int TABLE_ENTRIES = arpct_pkg::DEF_TABLE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst_n,
  arpct_req_if.sink      in_req,
  arpct_rsp_if.source    out_rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IP_W  = arpct_pkg::IP_W;
  localparam int MAC_W = arpct_pkg::MAC_W;
  localparam int IDX_OUT_W = arpct_pkg::IDX_OUT_W;
  localparam int CNT_OUT_W = arpct_pkg::CNT_OUT_W;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_OUT_W-1:0] ONE_OUT_CNT = CNT_OUT_W'(1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Table memory.
  logic [IP_W-1:0]  ip_mem  [TABLE_ENTRIES];
  logic [MAC_W-1:0] mac_mem [TABLE_ENTRIES];

  logic [1:0]        state_r,    state_nxt;
  logic              op_r,       op_nxt;
  logic [IP_W-1:0]   ip_r,       ip_nxt;
  logic [MAC_W-1:0]  mac_r,      mac_nxt;
  logic [CNT_W-1:0]  count_r,    count_nxt;
  logic              flushed_r,  flushed_nxt;
  logic [CNT_W-1:0]  scan_r,     scan_nxt;
  logic              cmp_vld_r,  cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r,  cmp_idx_nxt;
  logic              hit_r,      hit_nxt;
  logic [IDX_W-1:0]  res_idx_r,  res_idx_nxt;
  logic [MAC_W-1:0]  res_mac_r,  res_mac_nxt;
  logic [IP_W-1:0]   rd_ip_r;
  logic [MAC_W-1:0]  rd_mac_r;

  logic                  out_vld_r,   out_vld_nxt;
  logic                  out_hit_r,   out_hit_nxt;
  logic [IDX_OUT_W-1:0]  out_idx_r,   out_idx_nxt;
  logic [MAC_W-1:0]      out_mac_r,   out_mac_nxt;
  logic                  out_flush_r, out_flush_nxt;
  logic [CNT_OUT_W-1:0]  out_cnt_r,   out_cnt_nxt;

  logic              rd_en;
  logic              wr_en;
  logic              in_acc;
  logic              out_free;
  logic              cmp_hit;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign out_free     = !out_vld_r || out_rsp.ready;
  assign cmp_hit      = cmp_vld_r && (rd_ip_r == ip_r);

  // Sequencer and result formation.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ip_nxt        = ip_r;
    mac_nxt       = mac_r;
    count_nxt     = count_r;
    flushed_nxt   = flushed_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    hit_nxt       = hit_r;
    res_idx_nxt   = res_idx_r;
    res_mac_nxt   = res_mac_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_vld_nxt   = out_vld_r && !out_rsp.ready;
    out_hit_nxt   = out_hit_r;
    out_idx_nxt   = out_idx_r;
    out_mac_nxt   = out_mac_r;
    out_flush_nxt = out_flush_r;
    out_cnt_nxt   = out_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = in_req.operation;
          ip_nxt      = in_req.ip_addr;
          mac_nxt     = in_req.mac_addr;
          scan_nxt    = '0;
          flushed_nxt = 1'b0;
          // An add into a full table empties it first.
          if ((in_req.operation == arpct_pkg::OP_ADD) && (count_r >= FULL_CNT)) begin
            count_nxt   = '0;
            flushed_nxt = 1'b1;
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Compare the entry read last cycle while the next one is fetched.
        if (cmp_hit) begin
          hit_nxt     = 1'b1;
          res_idx_nxt = cmp_idx_r;
          res_mac_nxt = (op_r == arpct_pkg::OP_ADD) ? mac_r : rd_mac_r;
          state_nxt   = S_DONE;
        end else if (scan_r >= count_r) begin
          hit_nxt = 1'b0;
          if (op_r == arpct_pkg::OP_ADD) begin
            res_idx_nxt = count_r[IDX_W-1:0];
            res_mac_nxt = mac_r;
          end else begin
            res_idx_nxt = '0;
            res_mac_nxt = '0;
          end
          state_nxt = S_DONE;
        end else begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt    = scan_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        // Commit the write and the count once the output register is free.
        if (out_free) begin
          if (op_r == arpct_pkg::OP_ADD) begin
            wr_en = 1'b1;
            if (!hit_r) begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
          out_vld_nxt   = 1'b1;
          out_hit_nxt   = hit_r;
          out_idx_nxt   = IDX_OUT_W'(res_idx_r);
          out_mac_nxt   = res_mac_r;
          out_flush_nxt = flushed_r;
          out_cnt_nxt   = CNT_OUT_W'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      scan_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
      scan_r    <= scan_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ip_r        <= ip_nxt;
    mac_r       <= mac_nxt;
    flushed_r   <= flushed_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    hit_r       <= hit_nxt;
    res_idx_r   <= res_idx_nxt;
    res_mac_r   <= res_mac_nxt;
    out_hit_r   <= out_hit_nxt;
    out_idx_r   <= out_idx_nxt;
    out_mac_r   <= out_mac_nxt;
    out_flush_r <= out_flush_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[res_idx_r]  <= ip_r;
      mac_mem[res_idx_r] <= mac_r;
    end
    if (rd_en) begin
      rd_ip_r  <= ip_mem[scan_r[IDX_W-1:0]];
      rd_mac_r <= mac_mem[scan_r[IDX_W-1:0]];
    end
  end

  // Response port.
  assign out_rsp.valid         = out_vld_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.entry_index   = out_idx_r;
  assign out_rsp.mac_found     = out_mac_r;
  assign out_rsp.table_flushed = out_flush_r;
  assign out_rsp.entry_count   = out_cnt_r;

  // Checks on the sequencer and the fill count.
  `ARPCT_ASSERT_IMP(a_count_bound, 1'b1, count_r <= FULL_CNT, "fill count too large")
  `ARPCT_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, scan_r <= count_r, "scan overran")
  `ARPCT_ASSERT_NXT(a_busy_after_accept, in_acc, state_r == S_SCAN, "no scan")
  `ARPCT_ASSERT_IMP(a_flush_count, out_vld_r && out_flush_r, out_cnt_r == ONE_OUT_CNT, "flush")

endmodule

[bench/arp_cache_table_tb.sv]
`timescale 1ns / 100ps

module arp_cache_table_tb;

  localparam int OP_W         = arpct_pkg::OP_W;
  localparam int IP_W         = arpct_pkg::IP_W;
  localparam int MAC_W        = arpct_pkg::MAC_W;
  localparam int IDX_OUT_W    = arpct_pkg::IDX_OUT_W;
  localparam int CNT_OUT_W    = arpct_pkg::CNT_OUT_W;
  localparam int DEPTH        = arpct_pkg::DEF_TABLE_ENTRIES;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IP_POOL      = 24;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    bit               wait_drain;
  } arp_request_t;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] idx;
    logic [MAC_W-1:0]     mac;
    logic                 flushed;
    logic [CNT_OUT_W-1:0] count;
  } arp_response_t;

  logic clk;
  logic rst_n;

  arpct_req_if req_ch ();
  arpct_rsp_if rsp_ch ();

  arp_cache_table #(
    .TABLE_ENTRIES(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch.sink),
    .out_rsp(rsp_ch.source)
  );

  // Requests still to be sent, and the responses predicted for those already sent.
  arp_request_t  req_backlog[$];
  arp_response_t predicted_responses[$];

  // Shadow copy of the table.
  logic [IP_W-1:0]  shadow_ip[DEPTH];
  logic [MAC_W-1:0] shadow_mac[DEPTH];
  int               shadow_fill;

  int errors;
  int cycles;
  int requests_sent;
  int total_requests;
  int n_adds, n_lookups, n_hits, n_flushes, n_responses;
  bit quiet;

  // Work out the response to one request and update the shadow table.
  function automatic arp_response_t arp_table_apply(arp_request_t r);
    arp_response_t res;
    int k;
    int found;
    res = '0;
    if (r.op == arpct_pkg::OP_ADD) begin
      n_adds++;
      if (shadow_fill >= DEPTH) begin
        shadow_fill = 0;
        res.flushed = 1'b1;
        n_flushes++;
      end
      found = shadow_fill;
      for (k = 0; k < shadow_fill && found == shadow_fill; k++)
        if (shadow_ip[k] == r.ip) found = k;
      res.hit = (found < shadow_fill);
      if (!res.hit) shadow_fill++;
      shadow_ip[found]  = r.ip;
      shadow_mac[found] = r.mac;
      res.idx = found[IDX_OUT_W-1:0];
      res.mac = r.mac;
    end else begin
      n_lookups++;
      found = shadow_fill;
      for (k = 0; k < shadow_fill && found == shadow_fill; k++)
        if (shadow_ip[k] == r.ip) found = k;
      if (found < shadow_fill) begin
        res.hit = 1'b1;
        res.idx = found[IDX_OUT_W-1:0];
        res.mac = shadow_mac[found];
      end
    end
    if (res.hit) n_hits++;
    res.count = shadow_fill[CNT_OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    errors++;
  endtask

  task automatic queue_request(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
                               logic [MAC_W-1:0] mac, bit drain);
    arp_request_t r;
    r.op = op;
    r.ip = ip;
    r.mac = mac;
    r.wait_drain = drain;
    req_backlog.push_back(r);
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    return MAC_W'({$urandom(), $urandom()});
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses pending",
               cycles, predicted_responses.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Request driver: holds a request until it is taken, then maybe idles.
  int           idle_gap;
  arp_request_t cur_req;
  bit           req_fire;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      idle_gap = 0;
    end else begin
      req_fire = req_ch.valid && req_ch.ready;
      if (req_fire) begin
        predicted_responses.push_back(arp_table_apply(cur_req));
        requests_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) idle_gap = $urandom_range(1, 11);
      end
      quiet = (req_backlog.size() < QUIET_TAIL);
      if (req_ch.valid && !req_fire) begin
        // Keep the current request on the bus.
      end else if (idle_gap > 0) begin
        idle_gap--;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() > 0 &&
                   !(req_backlog[0].wait_drain && predicted_responses.size() != 0)) begin
        cur_req = req_backlog.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.operation <= cur_req.op;
        req_ch.ip_addr   <= cur_req.ip;
        req_ch.mac_addr  <= cur_req.mac;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response monitor: stalls in bursts and checks each response taken.
  int            stall_left;
  arp_response_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        n_responses++;
        if (predicted_responses.size() == 0) begin
          $display("[%0t] response arrived with no request outstanding", $time);
          errors++;
        end else begin
          want = predicted_responses.pop_front();
          if (rsp_ch.hit !== want.hit)
            report_mismatch("hit", 64'(rsp_ch.hit), 64'(want.hit));
          if (rsp_ch.entry_index !== want.idx)
            report_mismatch("entry_index", 64'(rsp_ch.entry_index), 64'(want.idx));
          if (rsp_ch.mac_found !== want.mac)
            report_mismatch("mac_found", 64'(rsp_ch.mac_found), 64'(want.mac));
          if (rsp_ch.table_flushed !== want.flushed)
            report_mismatch("table_flushed", 64'(rsp_ch.table_flushed), 64'(want.flushed));
          if (rsp_ch.entry_count !== want.count)
            report_mismatch("entry_count", 64'(rsp_ch.entry_count), 64'(want.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 10);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and the end of the run.
  logic [IP_W-1:0] ip_pool[IP_POOL];
  int i;
  int k;
  logic [IP_W-1:0] ip;

  initial begin
    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = arpct_pkg::OP_LOOKUP;
    req_ch.ip_addr   = '0;
    req_ch.mac_addr  = '0;
    rsp_ch.ready     = 1'b0;
    errors = 0;
    cycles = 0;
    requests_sent = 0;
    n_adds = 0;
    n_lookups = 0;
    n_hits = 0;
    n_flushes = 0;
    n_responses = 0;
    shadow_fill = 0;
    quiet = 1'b0;

    // Directed part: empty-table misses, the address extremes, an update in
    // place, a miss on a populated table, filling up, and the flush on add.
    queue_request(arpct_pkg::OP_LOOKUP, 32'h0000_0000, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'hFFFF_FFFF, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_ADD,    32'h0000_0000, 48'h0000_0000_0000, 1'b0);
    queue_request(arpct_pkg::OP_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'h0000_0000, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'hFFFF_FFFF, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_ADD,    32'h0000_0000, 48'hA5A5_5A5A_0123, 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'hC0A8_0001, random_mac(), 1'b0);
    for (k = 0; k < DEPTH - 2; k++)
      queue_request(arpct_pkg::OP_ADD, 32'h0A00_0000 + k, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_LOOKUP, 32'h0A00_0000 + DEPTH - 3, random_mac(), 1'b0);
    queue_request(arpct_pkg::OP_ADD,    32'hC0A8_0001, random_mac(), 1'b0);

    // Random part: mostly addresses from a small pool so that hits, updates
    // and flushes keep coming, with fully random addresses mixed in.
    for (k = 0; k < IP_POOL; k++) ip_pool[k] = $urandom();
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 4) == 0) ip = $urandom();
      else ip = ip_pool[$urandom_range(0, IP_POOL - 1)];
      queue_request($urandom_range(0, 1) ? arpct_pkg::OP_ADD : arpct_pkg::OP_LOOKUP,
                    ip, random_mac(), (i % 300) == 0);
    end
    total_requests = req_backlog.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (requests_sent < total_requests) @(posedge clk);
    while (predicted_responses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests (%0d adds, %0d lookups) and checked %0d responses.",
             requests_sent, n_adds, n_lookups, n_responses);
    $display("Saw %0d hits and %0d flushes of a full table.", n_hits, n_flushes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/arpct_pkg.sv
hdl/arpct_if.sv
hdl/arp_cache_table.sv
bench/arp_cache_table_tb.sv
